// ----- rtl/gbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_pkg: shared types and constants for the gshare predictor
// Transaction payload structs, opcodes, register indexes and defaults.
// ----------------------------------------------------------------------------
package gbp_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF    = 1024;
	localparam int unsigned COUNTER_MAG_BITS_DEF = 1;

	localparam int unsigned PC_W   = 10;
	localparam int unsigned HIST_W = 10;
	localparam int unsigned IDX_W  = 10;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_PC_SHIFT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIST_LEN  = 1'd1;

	localparam logic [CFG_DATA_W-1:0] PC_SHIFT_RST = 4'd2;
	localparam logic [CFG_DATA_W-1:0] HIST_LEN_RST = 4'd10;

	localparam logic OP_PREDICT = 1'b0;
	localparam logic OP_UPDATE  = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic              is_conditional;
		logic [PC_W-1:0]   pc_low;
		logic [HIST_W-1:0] global_history;
		logic              branch_taken;
	} gbp_req_t;

	typedef struct packed {
		logic              predicted_taken;
		logic [IDX_W-1:0]  table_index;
		logic [HIST_W-1:0] history_used;
	} gbp_rsp_t;

endpackage

// ----- rtl/gshare_branch_predictor_unit.sv -----
// Path: an accepted transaction is registered in stage 1 together with its
// counter read, then its result moves to the output register; both hold on rsp_stall.
// Throughput: one transaction per cycle while the output is not stalled; the
// counter memory read-modify-write loop closes through a forwarding register.
// Reset: after arst_n releases, a clearing pass writes zero to every counter,
// one entry per cycle for TABLE_ENTRIES cycles, with req_stall held high.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gshare_branch_predictor_unit: gshare branch direction predictor
// PC bits hashed with global history index a table of signed saturating
// counters held in a synchronous memory; predicts read it, updates step it.
// ----------------------------------------------------------------------------
module gshare_branch_predictor_unit #(
	parameter int unsigned TABLE_ENTRIES    = gbp_pkg::TABLE_ENTRIES_DEF,
	parameter int unsigned COUNTER_MAG_BITS = gbp_pkg::COUNTER_MAG_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  gbp_pkg::gbp_req_t              req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output gbp_pkg::gbp_rsp_t              rsp,
	input  logic                           cfg_we,
	input  logic [gbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gbp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import gbp_pkg::*;

	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned IW = (AW > IDX_W) ? AW : IDX_W;
	localparam int unsigned CW = COUNTER_MAG_BITS + 1;
	localparam logic [IDX_W-1:0] MASK10 =
		(AW >= IDX_W) ? {IDX_W{1'b1}} : IDX_W'((1 << AW) - 1);
	localparam logic [IW:0]   ENT      = (IW + 1)'(TABLE_ENTRIES);
	localparam logic [AW-1:0] LAST     = AW'(TABLE_ENTRIES - 1);
	localparam logic [CW-1:0] CNT_MAX  = {1'b0, {COUNTER_MAG_BITS{1'b1}}};
	localparam logic [CW-1:0] CNT_MIN  = {1'b1, {COUNTER_MAG_BITS{1'b0}}};

	logic [CW-1:0] mem [TABLE_ENTRIES];

	logic [CFG_DATA_W-1:0] pc_shift_q;
	logic [CFG_DATA_W-1:0] hist_len_q;

	logic          clearing_q;
	logic [AW-1:0] clr_q;

	logic              s1_valid_s1;
	gbp_req_t          req_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [HIST_W-1:0] hist_s1;
	logic [AW-1:0]     slot_s1;
	logic [CW-1:0]     rd_s1;
	logic              fwd_hit_s1;
	logic [CW-1:0]     fwd_data_s1;

	logic              accept;
	logic              out_ready;
	logic              s1_adv;
	logic              upd_wr;
	logic [HIST_W-1:0] hist_c;
	logic [IDX_W-1:0]  idx_c;
	logic [IW-1:0]     idx_ext;
	logic [IW-1:0]     slot_full;
	logic [AW-1:0]     slot_c;
	logic [CW-1:0]     cur_cnt;
	logic [CW-1:0]     new_cnt;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [CW-1:0]     mem_wd;
	gbp_rsp_t          rsp_c;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_shift_q <= PC_SHIFT_RST;
			hist_len_q <= HIST_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PC_SHIFT: pc_shift_q <= cfg_wdata;
				REG_HIST_LEN: hist_len_q <= cfg_wdata;
			endcase
		end
	end

	// index hash; shifts past the field width give zero, which covers large settings
	always_comb begin
		if (req.opcode == OP_PREDICT) begin
			hist_c = req.global_history & ~({HIST_W{1'b1}} << hist_len_q);
		end else begin
			hist_c = req.global_history;
		end
		idx_c     = (((req.pc_low & MASK10) >> pc_shift_q) ^ hist_c) & MASK10;
		idx_ext   = IW'(idx_c);
		slot_full = ({1'b0, idx_ext} >= ENT) ? (idx_ext - ENT[IW-1:0]) : idx_ext;
		slot_c    = slot_full[AW-1:0];
	end

	assign out_ready = !rsp_valid || !rsp_stall;
	assign s1_adv    = s1_valid_s1 && out_ready;
	assign req_stall = clearing_q || (s1_valid_s1 && !out_ready);
	assign accept    = req_valid && !req_stall;
	assign upd_wr    = s1_adv && req_s1.is_conditional && (req_s1.opcode == OP_UPDATE);

	// saturating step of the counter seen by the item in stage 1
	always_comb begin
		cur_cnt = fwd_hit_s1 ? fwd_data_s1 : rd_s1;
		new_cnt = cur_cnt;
		if (req_s1.branch_taken) begin
			if (cur_cnt != CNT_MAX) new_cnt = cur_cnt + CW'(1);
		end else begin
			if (cur_cnt != CNT_MIN) new_cnt = cur_cnt - CW'(1);
		end
	end

	always_comb begin
		if (clearing_q) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else begin
			mem_we = upd_wr;
			mem_wa = slot_s1;
			mem_wd = new_cnt;
		end
	end

	// counter memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (accept) rd_s1 <= mem[slot_c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == LAST) clearing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload; forward a write landing on the entry just read
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1      <= req;
			idx_s1      <= idx_c;
			hist_s1     <= hist_c;
			slot_s1     <= slot_c;
			fwd_hit_s1  <= upd_wr && (slot_s1 == slot_c);
			fwd_data_s1 <= new_cnt;
		end
	end

	always_comb begin
		if (!req_s1.is_conditional) begin
			rsp_c.predicted_taken = req_s1.branch_taken;
			rsp_c.table_index     = '0;
			rsp_c.history_used    = '0;
		end else begin
			if (req_s1.opcode == OP_PREDICT) begin
				rsp_c.predicted_taken = !cur_cnt[CW-1];
			end else begin
				rsp_c.predicted_taken = req_s1.branch_taken;
			end
			rsp_c.table_index  = idx_s1;
			rsp_c.history_used = hist_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (out_ready) begin
			rsp_valid <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) rsp <= rsp_c;
	end

	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !s1_valid_s1)
		else $error("item in flight during clearing pass");

	a_fwd_same_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && upd_wr && (slot_s1 == slot_c)) |=> fwd_hit_s1)
		else $error("back-to-back access to updated entry not forwarded");

	a_rsp_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(s1_valid_s1))
		else $error("result appeared without an item in stage 1");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !out_ready) |=> s1_valid_s1)
		else $error("stage 1 item dropped while output stalled");

endmodule

// ----- tb/gbp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbp_checker: result checker for the gshare predictor
// Watches the request, response and register ports, runs its own copy of the
// counter table and register values, and compares each response transaction
// field by field with the oldest outstanding expected response.
// ----------------------------------------------------------------------------
module gbp_checker #(
	parameter int unsigned TABLE_ENTRIES    = gbp_pkg::TABLE_ENTRIES_DEF,
	parameter int unsigned COUNTER_MAG_BITS = gbp_pkg::COUNTER_MAG_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic                           req_stall,
	input  gbp_pkg::gbp_req_t              req,
	input  logic                           rsp_valid,
	input  logic                           rsp_stall,
	input  gbp_pkg::gbp_rsp_t              rsp,
	input  logic                           cfg_we,
	input  logic [gbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gbp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                             errors,
	output int                             pending,
	output int                             checked
);
	import gbp_pkg::*;

	localparam int unsigned SPAN_MASK = (1 << $clog2(TABLE_ENTRIES)) - 1;
	localparam int COUNT_HI  = (1 << COUNTER_MAG_BITS) - 1;
	localparam int COUNT_LO  = -COUNT_HI - 1;
	localparam int MAX_LINES = 40;

	logic signed [COUNTER_MAG_BITS:0] ctr_bank [TABLE_ENTRIES];
	logic [CFG_DATA_W-1:0] pc_shift_q;
	logic [CFG_DATA_W-1:0] hist_len_q;
	gbp_rsp_t outcome_q [$];
	gbp_rsp_t want;

	task automatic report_mismatch(input string what, input logic [31:0] seen,
			input logic [31:0] wanted);
		if (errors < MAX_LINES)
			$display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, seen, wanted);
		errors++;
	endtask

	// Look up or step the counter for one branch and build its response.
	function automatic gbp_rsp_t forecast_branch(input gbp_req_t r);
		gbp_rsp_t o;
		int unsigned h;
		int unsigned idx;
		int c;
		o = '0;
		o.predicted_taken = r.branch_taken;
		if (!r.is_conditional)
			return o;
		h = 32'(r.global_history);
		// a predict folds in only the configured history bits
		if (r.opcode == OP_PREDICT)
			h = h & ((1 << hist_len_q) - 1);
		idx = (((r.pc_low & SPAN_MASK) >> pc_shift_q) ^ h) & SPAN_MASK;
		o.table_index  = IDX_W'(idx);
		o.history_used = HIST_W'(h);
		if (idx >= TABLE_ENTRIES)
			idx -= TABLE_ENTRIES;
		c = int'(ctr_bank[idx]);
		if (r.opcode == OP_PREDICT) begin
			o.predicted_taken = (c >= 0);
		end else begin
			if (r.branch_taken && c < COUNT_HI)
				c++;
			else if (!r.branch_taken && c > COUNT_LO)
				c--;
			ctr_bank[idx] = c[COUNTER_MAG_BITS:0];
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_shift_q = PC_SHIFT_RST;
			hist_len_q = HIST_LEN_RST;
			foreach (ctr_bank[i])
				ctr_bank[i] = '0;
			outcome_q.delete();
			pending = 0;
			errors  = 0;
			checked = 0;
		end else begin
			if (req_valid && !req_stall)
				outcome_q.push_back(forecast_branch(req));
			if (rsp_valid && !rsp_stall) begin
				if (outcome_q.size() == 0) begin
					report_mismatch("unexpected transaction", 32'(rsp), 32'(0));
				end else begin
					want = outcome_q.pop_front();
					if (rsp.predicted_taken !== want.predicted_taken)
						report_mismatch("predicted_taken", 32'(rsp.predicted_taken),
							32'(want.predicted_taken));
					if (rsp.table_index !== want.table_index)
						report_mismatch("table_index", 32'(rsp.table_index),
							32'(want.table_index));
					if (rsp.history_used !== want.history_used)
						report_mismatch("history_used", 32'(rsp.history_used),
							32'(want.history_used));
					checked++;
				end
			end
			// a register write lands after any transaction at the same edge
			if (cfg_we) begin
				case (cfg_index)
					REG_PC_SHIFT: pc_shift_q = cfg_wdata;
					REG_HIST_LEN: hist_len_q = cfg_wdata;
					default: ;
				endcase
			end
			pending = outcome_q.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the gshare predictor
// Drives directed and random predict/update traffic through a series of
// register settings, with random idle cycles on both channels, and reports
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
	import gbp_pkg::*;

	localparam int STALL_LIMIT  = 5000;
	localparam int PHASES       = 9;
	localparam int PHASE_ITEMS  = 120;
	localparam int REQ_W        = $bits(gbp_req_t);

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	gbp_req_t              req       = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	gbp_rsp_t              rsp;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_PC_SHIFT;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int errors;
	int pending;
	int checked;

	bit          calm        = 1'b0;
	int unsigned hlen_now    = 32'(HIST_LEN_RST);
	int          sent        = 0;
	int          settings    = 0;
	int          quiet_count = 0;

	int unsigned shift_plan [PHASES] = '{0, 9, 4, 10, 1, 15, 0, 3, 7};
	int unsigned hlen_plan  [PHASES] = '{10, 0, 5, 11, 3, 15, 0, 8, 1};
	logic [PC_W-1:0]   pc_pool   [8];
	logic [HIST_W-1:0] hist_pool [4];

	gshare_branch_predictor_unit dut (.*);
	gbp_checker u_watch (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		rsp_stall <= !calm && ($urandom_range(99) < 31);

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_count <= 0;
		end else begin
			quiet_count <= quiet_count + 1;
			if (quiet_count >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Offer one transaction after a random gap and hold it until taken.
	task automatic push_branch(input gbp_req_t r);
		while (!calm && $urandom_range(99) < 31) begin
			req_valid <= 1'b0;
			req <= REQ_W'($urandom);
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (req_stall);
		sent++;
	endtask

	task automatic push_fields(input logic op, input logic cond, input logic [PC_W-1:0] pc,
			input logic [HIST_W-1:0] hist, input logic taken);
		push_branch({op, cond, pc, hist, taken});
	endtask

	// Let every result come back, then write both registers.
	task automatic drain_and_program(input int unsigned pc_sh, input int unsigned h_len);
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PC_SHIFT;
		cfg_wdata <= CFG_DATA_W'(pc_sh);
		@(posedge clk);
		cfg_index <= REG_HIST_LEN;
		cfg_wdata <= CFG_DATA_W'(h_len);
		@(posedge clk);
		cfg_we <= 1'b0;
		hlen_now = h_len;
		settings++;
	endtask

	function automatic gbp_req_t random_branch();
		gbp_req_t r;
		r.opcode = ($urandom_range(99) < 45) ? OP_UPDATE : OP_PREDICT;
		r.is_conditional = ($urandom_range(99) < 85);
		r.pc_low = ($urandom_range(99) < 80) ? pc_pool[$urandom_range(7)] : PC_W'($urandom);
		r.global_history = ($urandom_range(99) < 75) ? hist_pool[$urandom_range(3)] :
			HIST_W'($urandom);
		// an update mostly carries the history as masked at predict time
		if (r.opcode == OP_UPDATE && $urandom_range(99) < 70)
			r.global_history = r.global_history & HIST_W'((1 << hlen_now) - 1);
		r.branch_taken = 1'($urandom_range(1));
		return r;
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		settings = 1;

		// reset register values: pass-through, then walk one counter end to end
		push_fields(OP_PREDICT, 1'b0, '1, '1, 1'b1);
		push_fields(OP_PREDICT, 1'b0, '0, '0, 1'b0);
		push_fields(OP_UPDATE, 1'b0, '1, '1, 1'b0);
		push_fields(OP_PREDICT, 1'b1, '1, '1, 1'b0);
		repeat (3) push_fields(OP_UPDATE, 1'b1, '0, '0, 1'b0);
		push_fields(OP_PREDICT, 1'b1, '0, '0, 1'b1);
		push_fields(OP_UPDATE, 1'b1, '0, '0, 1'b1);
		push_fields(OP_PREDICT, 1'b1, '0, '0, 1'b1);
		repeat (3) push_fields(OP_UPDATE, 1'b1, '0, '0, 1'b1);
		push_fields(OP_PREDICT, 1'b1, '0, '0, 1'b0);
		push_fields(OP_UPDATE, 1'b1, '1, '1, 1'b0);
		push_fields(OP_PREDICT, 1'b1, '1, '1, 1'b1);

		// shift past the pc width, no history on predict
		drain_and_program(15, 0);
		push_fields(OP_PREDICT, 1'b1, '1, '1, 1'b0);
		push_fields(OP_UPDATE, 1'b1, '1, '1, 1'b1);

		// no shift, history length beyond its width
		drain_and_program(0, 15);
		push_fields(OP_PREDICT, 1'b1, 10'h155, 10'h2aa, 1'b0);
		push_fields(OP_UPDATE, 1'b1, 10'h2aa, 10'h155, 1'b0);
		push_fields(OP_PREDICT, 1'b1, '1, '0, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			drain_and_program(shift_plan[p], hlen_plan[p]);
			calm = (p == 3);
			foreach (pc_pool[i])
				pc_pool[i] = PC_W'($urandom);
			foreach (hist_pool[i])
				hist_pool[i] = HIST_W'($urandom);
			repeat (PHASE_ITEMS) push_branch(random_branch());
		end
		calm = 1'b0;

		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d transactions, checked %0d results over %0d register settings",
			sent, checked, settings);
		$display("pc shift and history length swept across 0..15, counters run to both limits");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
